// ===== sv/dct_pkg.sv =====
// Shared types, codes and tables for the DMA channel transfer bookkeeping block.
package dct_pkg;

	localparam logic [1:0] FN_READ  = 2'd0;
	localparam logic [1:0] FN_WRITE = 2'd1;
	localparam logic [1:0] FN_FETCH = 2'd2;
	localparam logic [1:0] FN_PUT   = 2'd3;

	localparam logic [2:0] SEL_SRC  = 3'd0;
	localparam logic [2:0] SEL_DST  = 3'd1;
	localparam logic [2:0] SEL_CNT  = 3'd2;
	localparam logic [2:0] SEL_CTL  = 3'd3;
	localparam logic [2:0] SEL_OP   = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DISABLED = 2'd1;
	localparam logic [1:0] ST_RESOURCE = 2'd2;
	localparam logic [1:0] ST_BAD_MODE = 2'd3;

	localparam logic [1:0] MODE_FIXED = 2'd0;
	localparam logic [1:0] MODE_INC   = 2'd1;
	localparam logic [1:0] MODE_DEC   = 2'd2;
	localparam logic [1:0] MODE_BAD   = 2'd3;

	localparam logic [3:0] RES_FETCH = 4'h2;
	localparam logic [3:0] RES_PUT   = 4'h3;

	localparam int CTL_TE_BIT = 1;
	localparam int CTL_IE_BIT = 2;

	localparam int IRQ_LINES = 4;

	typedef struct packed {
		logic        present;
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] cnt;
		logic [31:0] ctl;
		logic [31:0] op;
	} chan_rd_t;

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] cnt;
		logic [31:0] ctl;
	} chan_regs_t;

	typedef struct packed {
		logic        wr_src;
		logic        wr_dst;
		logic        wr_cnt;
		logic        wr_ctl;
		logic        wr_op;
		logic        irq_set;
		logic        irq_clr;
		logic [31:0] src_val;
		logic [31:0] dst_val;
		logic [31:0] cnt_val;
		logic [31:0] ctl_val;
		logic [31:0] op_val;
	} upd_t;

	typedef struct packed {
		logic [31:0] rdata;
		logic [1:0]  status;
		logic [31:0] start_addr;
		logic [1:0]  step_mode;
		logic [5:0]  unit_size;
		logic [29:0] bytes_done;
		logic        transfer_end;
	} result_t;

	// log2 of the unit size table {8, 1, 2, 4, 32, 1, 1, 1}
	function automatic logic [2:0] unit_shift(input logic [2:0] code);
		logic [2:0] sh;
		case (code)
			3'd0:    sh = 3'd3;
			3'd2:    sh = 3'd1;
			3'd3:    sh = 3'd2;
			3'd4:    sh = 3'd5;
			default: sh = 3'd0;
		endcase
		return sh;
	endfunction

	function automatic logic irq_active(input logic [31:0] ctl);
		return ctl[CTL_IE_BIT] & ctl[CTL_TE_BIT];
	endfunction

endpackage

// ===== sv/dct_xfer.sv =====
// Per-beat decode: register access and transfer bookkeeping for one channel.
module dct_xfer #(
	parameter int COUNT_BITS = 24
) (
	input  logic [1:0]        func,
	input  logic [2:0]        reg_sel,
	input  logic [31:0]       wdata,
	input  logic [31:0]       num_bytes,
	input  dct_pkg::chan_rd_t rd,
	output dct_pkg::upd_t     upd,
	output dct_pkg::result_t  res
);

	localparam int CW = COUNT_BITS + 1;

	logic              is_put;
	logic [31:0]       ctl;
	logic [1:0]        mode;
	logic [1:0]        st;
	logic [2:0]        sh;
	logic [31:0]       units_raw;
	logic [CW-1:0]     count;
	logic [CW-1:0]     units_c;
	logic [CW-1:0]     left;
	logic [CW+4:0]     prod;
	logic [31:0]       addr;
	logic [31:0]       moved;
	logic [31:0]       new_addr;
	logic              over;

	always_comb begin
		is_put = (func == dct_pkg::FN_PUT);
		ctl    = rd.present ? rd.ctl : 32'd0;
		mode   = is_put ? ctl[15:14] : ctl[13:12];

		if (!rd.present || ctl[1:0] != 2'd1 || rd.op[2:0] != 3'd1)
			st = dct_pkg::ST_DISABLED;
		else if (ctl[11:8] != (is_put ? dct_pkg::RES_PUT : dct_pkg::RES_FETCH))
			st = dct_pkg::ST_RESOURCE;
		else if (mode == dct_pkg::MODE_BAD)
			st = dct_pkg::ST_BAD_MODE;
		else
			st = dct_pkg::ST_OK;

		sh        = dct_pkg::unit_shift(ctl[6:4]);
		units_raw = num_bytes >> sh;
		count     = {1'b0, rd.cnt[COUNT_BITS-1:0]};
		if (count == '0)
			count = CW'(1) << COUNT_BITS;
		over    = {1'b0, units_raw} > 33'(count);
		units_c = (over || units_raw == 32'd0) ? count : CW'(units_raw);
		left    = count - units_c;
		prod    = (CW+5)'(units_c) << sh;
		moved   = 32'(prod);
		addr    = is_put ? rd.dst : rd.src;
		case (mode)
			dct_pkg::MODE_INC: new_addr = addr + moved;
			dct_pkg::MODE_DEC: new_addr = addr - moved;
			default:           new_addr = addr;
		endcase

		upd         = '0;
		upd.src_val = wdata;
		upd.dst_val = wdata;
		upd.cnt_val = wdata;
		upd.ctl_val = wdata;
		upd.op_val  = wdata;
		res         = '0;

		case (func)
			dct_pkg::FN_READ: begin
				case (reg_sel)
					dct_pkg::SEL_OP:  res.rdata = rd.op;
					dct_pkg::SEL_SRC: res.rdata = rd.present ? rd.src : 32'd0;
					dct_pkg::SEL_DST: res.rdata = rd.present ? rd.dst : 32'd0;
					dct_pkg::SEL_CNT: res.rdata = rd.present ? rd.cnt : 32'd0;
					dct_pkg::SEL_CTL: res.rdata = rd.present ? rd.ctl : 32'd0;
					default:          res.rdata = 32'd0;
				endcase
			end
			dct_pkg::FN_WRITE: begin
				case (reg_sel)
					dct_pkg::SEL_OP:  upd.wr_op  = 1'b1;
					dct_pkg::SEL_SRC: upd.wr_src = rd.present;
					dct_pkg::SEL_DST: upd.wr_dst = rd.present;
					dct_pkg::SEL_CNT: upd.wr_cnt = rd.present;
					dct_pkg::SEL_CTL: begin
						upd.wr_ctl  = rd.present;
						upd.irq_clr = rd.present && dct_pkg::irq_active(rd.ctl)
							&& !dct_pkg::irq_active(wdata);
					end
					default: upd.wr_op = 1'b0;
				endcase
			end
			default: begin
				res.status = st;
				if (st == dct_pkg::ST_OK) begin
					res.start_addr = addr;
					res.step_mode  = mode;
					res.unit_size  = 6'd1 << sh;
					res.bytes_done = 30'(prod);
					upd.wr_src     = !is_put;
					upd.wr_dst     = is_put;
					upd.src_val    = new_addr;
					upd.dst_val    = new_addr;
					upd.wr_cnt     = 1'b1;
					upd.cnt_val    = 32'(left[COUNT_BITS-1:0]);
					if (left == '0) begin
						res.transfer_end = 1'b1;
						upd.wr_ctl       = 1'b1;
						upd.ctl_val      = ctl | (32'd1 << dct_pkg::CTL_TE_BIT);
						upd.irq_set      = ctl[dct_pkg::CTL_IE_BIT];
					end
				end
			end
		endcase
	end

endmodule

// ===== sv/dct_regfile.sv =====
// Channel register file, global operation register and interrupt lines.
module dct_regfile #(
	parameter int NUM_CHANNELS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        channel,
	input  logic              commit,
	input  dct_pkg::upd_t     upd,
	output dct_pkg::chan_rd_t rd,
	output logic [dct_pkg::IRQ_LINES-1:0] irq_next
);

	dct_pkg::chan_regs_t     chan_q [NUM_CHANNELS];
	logic [31:0]             op_q;
	logic [NUM_CHANNELS-1:0] irq_q;
	logic [NUM_CHANNELS-1:0] hit;
	logic [NUM_CHANNELS-1:0] irq_nx;

	always_comb begin
		rd    = '0;
		rd.op = op_q;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			hit[i] = (4'(channel) == 4'(i));
			if (hit[i]) begin
				rd.present = 1'b1;
				rd.src     = chan_q[i].src;
				rd.dst     = chan_q[i].dst;
				rd.cnt     = chan_q[i].cnt;
				rd.ctl     = chan_q[i].ctl;
			end
			if (hit[i] && upd.irq_clr)
				irq_nx[i] = 1'b0;
			else if (hit[i] && upd.irq_set)
				irq_nx[i] = 1'b1;
			else
				irq_nx[i] = irq_q[i];
		end
		irq_next = '0;
		for (int i = 0; i < NUM_CHANNELS && i < dct_pkg::IRQ_LINES; i++)
			irq_next[i] = irq_nx[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q  <= 32'd0;
			irq_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++)
				chan_q[i] <= '0;
		end else if (commit) begin
			irq_q <= irq_nx;
			if (upd.wr_op)
				op_q <= upd.op_val;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (hit[i]) begin
					if (upd.wr_src)
						chan_q[i].src <= upd.src_val;
					if (upd.wr_dst)
						chan_q[i].dst <= upd.dst_val;
					if (upd.wr_cnt)
						chan_q[i].cnt <= upd.cnt_val;
					if (upd.wr_ctl)
						chan_q[i].ctl <= upd.ctl_val;
				end
			end
		end
	end

endmodule

// ===== sv/dma_channel_transfer_bookkeeping.sv =====
// Top level of the DMA channel transfer bookkeeping block.
//
// Request channel (req_valid / req_stall) carries one beat per register read,
// register write, memory-to-device fetch or device-to-memory put. Response
// channel (rsp_valid / rsp_stall) returns exactly one beat per request, in
// order: read data, request status, start address, step mode, unit size,
// bytes moved, transfer-end flag and the interrupt lines after the beat.
// A beat moves when valid is high and stall is low at a rising clock edge.
//
// A request lands in an input register, then the decode and register-file
// update run on it and the result lands in the response register. One beat
// per cycle is sustained while the receiver does not stall; the register file
// is written as the result is registered, so the next beat sees it.
//
// When the receiver stalls, the response register holds and the input
// register keeps one more beat; req_stall rises once both are full.
// arst_n clears all channel registers, the operation register, the
// interrupt lines and both valid flags; no clearing pass is needed.
module dma_channel_transfer_bookkeeping #(
	parameter int NUM_CHANNELS = 4,
	parameter int COUNT_BITS   = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  func,
	input  logic [1:0]  channel,
	input  logic [2:0]  reg_sel,
	input  logic [31:0] wdata,
	input  logic [31:0] num_bytes,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] rdata,
	output logic [1:0]  status,
	output logic [31:0] start_addr,
	output logic [1:0]  step_mode,
	output logic [5:0]  unit_size,
	output logic [29:0] bytes_done,
	output logic        transfer_end,
	output logic [3:0]  irq_lines
);

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [1:0]  channel_s1;
	logic [2:0]  reg_sel_s1;
	logic [31:0] wdata_s1;
	logic [31:0] num_bytes_s1;

	logic                   valid_s2;
	dct_pkg::result_t       res_s2;
	logic [3:0]             irq_s2;

	logic              adv;
	logic              commit;
	dct_pkg::chan_rd_t rd;
	dct_pkg::upd_t     upd;
	dct_pkg::result_t  res;
	logic [3:0]        irq_next;

	assign adv       = !valid_s2 || !rsp_stall;
	assign req_stall = valid_s1 && !adv;
	assign commit    = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!req_stall)
				valid_s1 <= req_valid;
			if (adv)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			func_s1      <= func;
			channel_s1   <= channel;
			reg_sel_s1   <= reg_sel;
			wdata_s1     <= wdata;
			num_bytes_s1 <= num_bytes;
		end
		if (commit) begin
			res_s2 <= res;
			irq_s2 <= irq_next;
		end
	end

	dct_regfile #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.channel  (channel_s1),
		.commit   (commit),
		.upd      (upd),
		.rd       (rd),
		.irq_next (irq_next)
	);

	dct_xfer #(
		.COUNT_BITS(COUNT_BITS)
	) u_xfer (
		.func      (func_s1),
		.reg_sel   (reg_sel_s1),
		.wdata     (wdata_s1),
		.num_bytes (num_bytes_s1),
		.rd        (rd),
		.upd       (upd),
		.res       (res)
	);

	assign rsp_valid    = valid_s2;
	assign rdata        = res_s2.rdata;
	assign status       = res_s2.status;
	assign start_addr   = res_s2.start_addr;
	assign step_mode    = res_s2.step_mode;
	assign unit_size    = res_s2.unit_size;
	assign bytes_done   = res_s2.bytes_done;
	assign transfer_end = res_s2.transfer_end;
	assign irq_lines    = irq_s2;

endmodule

// ===== sv/dct_checker.sv =====
// Port-level checks for the DMA channel transfer bookkeeping block, with bind.
module dct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [31:0] rdata,
	input logic [1:0]  status,
	input logic [31:0] start_addr,
	input logic [1:0]  step_mode,
	input logic [5:0]  unit_size,
	input logic [29:0] bytes_done,
	input logic        transfer_end
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response beat dropped while stalled");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != dct_pkg::ST_OK |->
			bytes_done == 30'd0 && start_addr == 32'd0 && !transfer_end
			&& unit_size == 6'd0)
		else $error("failed request reports a transfer");

	a_end_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && transfer_end |-> status == dct_pkg::ST_OK && unit_size != 6'd0)
		else $error("transfer end without a granted request");

	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rdata != 32'd0 |->
			status == dct_pkg::ST_OK && unit_size == 6'd0 && !transfer_end)
		else $error("read data mixed with transfer fields");

	a_unit_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && unit_size != 6'd0 |->
			(unit_size == 6'd1 || unit_size == 6'd2 || unit_size == 6'd4
			|| unit_size == 6'd8 || unit_size == 6'd32)
			&& step_mode != dct_pkg::MODE_BAD)
		else $error("illegal unit size or step mode reported");

endmodule

bind dma_channel_transfer_bookkeeping dct_checker u_dct_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.rdata        (rdata),
	.status       (status),
	.start_addr   (start_addr),
	.step_mode    (step_mode),
	.unit_size    (unit_size),
	.bytes_done   (bytes_done),
	.transfer_end (transfer_end)
);
